// ===== sv/fir_filter_circular_delay_defines.svh =====
// Assertion macros used by the filter top level.
`ifndef FIR_FILTER_CIRCULAR_DELAY_DEFINES_SVH
`define FIR_FILTER_CIRCULAR_DELAY_DEFINES_SVH

// Same-cycle implication check.
`define FCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fir filter check failed");

// Next-cycle implication check.
`define FCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fir filter check failed");

`endif

// ===== sv/fcd_pkg.sv =====
// Package: constants, request codes and control structs of the FIR filter.
`timescale 1ns / 1ps
package fcd_pkg;

	localparam int TAPS_DEF        = 63;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_BITS       = 24;
	localparam int COEF_FRAC       = 25;
	localparam int ACC_BITS        = 39;
	localparam int ACC_FRAC        = 35;

	// Request codes carried by req_type
	localparam logic REQ_FILTER = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear_we;   // write zero to both memories at the tap counter
		logic start;      // sample accepted: store it, clear accumulator
		logic coef_we;    // coefficient item accepted
		logic issue;      // read one tap pair
		logic load_out;   // capture the accumulator into the output register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic last_tap;   // tap counter at its last value
		logic busy;       // multiply-accumulate pipeline still holds work
	} status_t;

endpackage

// ===== sv/fir_filter_circular_delay.sv =====
// Top level of the direct-form FIR filter with a circular delay line.
// A sample item (req_type 0) is stored in the circular delay line and one
// shared multiply-accumulate unit then steps through the TAPS taps, one tap
// per cycle, reading the delay memory and the coefficient memory; no new
// item is taken until the result is captured into the output register,
// where it may still wait while the next sample is processed. A coefficient
// item (req_type 1) writes one table entry in the cycle it is taken and
// yields no result; indexes of TAPS and above are dropped. After reset a
// clearing pass zeroes both memories, and no item is taken until it ends.
// Products are floored to 35 fraction bits, summed in a wrapping 39-bit
// accumulator, and the output is floored and wrapped to SAMPLE_BITS bits
// without saturation.
`timescale 1ns / 1ps
`include "fir_filter_circular_delay_defines.svh"
module fir_filter_circular_delay #(
	parameter int TAPS        = fcd_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = fcd_pkg::SAMPLE_BITS_DEF,
	localparam int IDX_W      = $clog2(TAPS)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic        [IDX_W-1:0]              coef_index,
	input  logic signed [fcd_pkg::COEF_BITS-1:0] coef_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]        filtered
);
	import fcd_pkg::*;

	cmd_t    cmd;
	status_t status;

	fcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	fcd_datapath #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sample     (sample),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.status     (status),
		.filtered   (filtered)
	);

	// A taken sample locks the input until its result is captured
	`FCD_ASSERT_NEXT(a_sample_locks_input, clk, arst_n, cmd.start, in_stall)
	// Taps are never read while an item can be taken
	`FCD_ASSERT_NOW(a_issue_stalls_input, clk, arst_n, cmd.issue, in_stall)
	// The result is captured only after the pipeline has drained
	`FCD_ASSERT_NOW(a_load_after_drain, clk, arst_n, cmd.load_out, !status.busy && !cmd.issue)
	// A captured result is presented in the next cycle
	`FCD_ASSERT_NEXT(a_load_shows_result, clk, arst_n, cmd.load_out, out_valid)

endmodule

// ===== sv/fcd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module fcd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/fcd_ctrl.sv =====
// Controller: sequences clearing, tap iteration and result hand-off.
`timescale 1ns / 1ps
module fcd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            req_type,
	input  logic            out_stall,
	input  fcd_pkg::status_t status,
	output fcd_pkg::cmd_t   cmd,
	output logic            in_stall,
	output logic            out_valid
);
	import fcd_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_acc;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.clear_we = (state_q == ST_CLEAR);
		cmd.start    = in_acc && (req_type == REQ_FILTER);
		cmd.coef_we  = in_acc && (req_type == REQ_COEF);
		cmd.issue    = (state_q == ST_RUN);
		cmd.load_out = (state_q == ST_FINISH) && out_free;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (status.last_tap) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.start) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (status.last_tap) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!status.busy) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

// ===== sv/fcd_datapath.sv =====
// Datapath: delay and coefficient memories, pointers, multiply-accumulate.
`timescale 1ns / 1ps
module fcd_datapath #(
	parameter int TAPS        = fcd_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = fcd_pkg::SAMPLE_BITS_DEF,
	localparam int IDX_W      = $clog2(TAPS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fcd_pkg::cmd_t                       cmd,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic        [IDX_W-1:0]             coef_index,
	input  logic signed [fcd_pkg::COEF_BITS-1:0] coef_value,
	output fcd_pkg::status_t                    status,
	output logic signed [SAMPLE_BITS-1:0]       filtered
);
	import fcd_pkg::*;

	localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
	localparam int EXT_W  = PROD_W + ACC_BITS;
	localparam int SHIFT  = COEF_FRAC + SAMPLE_BITS - 1 - ACC_FRAC;
	localparam int RSH    = (SHIFT > 0) ? SHIFT : 0;
	localparam int LSH    = (SHIFT < 0) ? -SHIFT : 0;
	localparam int OUT_SH = ACC_FRAC - (SAMPLE_BITS - 1);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TAPS - 1);
	localparam logic [IDX_W-1:0] ONE  = IDX_W'(1);

	logic [IDX_W-1:0] k_q;       // tap counter, also the clearing address
	logic [IDX_W-1:0] wp_q;      // slot for the next sample
	logic [IDX_W-1:0] rd_ptr_q;  // delay-line read address
	logic             v_s1;
	logic             v_s2;

	logic signed [COEF_BITS-1:0]   coef_rd;
	logic signed [SAMPLE_BITS-1:0] smp_rd;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [EXT_W-1:0]       prod_ext;
	logic signed [EXT_W-1:0]       scaled;
	logic        [ACC_BITS-1:0]    term;
	logic        [ACC_BITS-1:0]    acc_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;

	logic                   dl_we;
	logic [IDX_W-1:0]       dl_waddr;
	logic [SAMPLE_BITS-1:0] dl_wdata;
	logic                   cf_we;
	logic [IDX_W-1:0]       cf_waddr;
	logic [COEF_BITS-1:0]   cf_wdata;
	logic                   idx_ok;

	// Memory write selection
	assign idx_ok   = ({1'b0, coef_index} < (IDX_W + 1)'(TAPS));
	assign dl_we    = cmd.clear_we || cmd.start;
	assign dl_waddr = cmd.clear_we ? k_q : wp_q;
	assign dl_wdata = cmd.clear_we ? '0 : sample;
	assign cf_we    = cmd.clear_we || (cmd.coef_we && idx_ok);
	assign cf_waddr = cmd.clear_we ? k_q : coef_index;
	assign cf_wdata = cmd.clear_we ? '0 : coef_value;

	fcd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAPS)) u_delay_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (dl_waddr),
		.wdata (dl_wdata),
		.raddr (rd_ptr_q),
		.rdata (smp_rd)
	);

	fcd_ram #(.WIDTH(COEF_BITS), .DEPTH(TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (cf_we),
		.waddr (cf_waddr),
		.wdata (cf_wdata),
		.raddr (k_q),
		.rdata (coef_rd)
	);

	// Pointers, tap counter and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			wp_q     <= '0;
			rd_ptr_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.clear_we || cmd.issue) begin
				k_q <= (k_q == LAST) ? '0 : k_q + ONE;
			end
			if (cmd.issue) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + ONE;
			end
			// new sample sits at wp; the walk starts there, wp moves down
			if (cmd.start) begin
				k_q      <= '0;
				rd_ptr_q <= wp_q;
				wp_q     <= (wp_q == '0) ? LAST : wp_q - ONE;
			end
		end
	end

	// Product floored to the accumulator's fraction bits
	always_comb begin
		prod_ext = {{ACC_BITS{prod_s2[PROD_W-1]}}, prod_s2};
		scaled   = (prod_ext >>> RSH) <<< LSH;
		term     = scaled[ACC_BITS-1:0];
	end

	// Multiply and accumulate
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= PROD_W'(coef_rd) * PROD_W'(smp_rd);
		end
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + term;
		end
		if (cmd.load_out) begin
			filtered_q <= acc_q[OUT_SH +: SAMPLE_BITS];
		end
	end

	assign status.last_tap = (k_q == LAST);
	assign status.busy     = v_s1 || v_s2;
	assign filtered        = filtered_q;

endmodule
